// ===== design/dksf_pkg.sv =====
// Shared types and constants for the duplicate key suppression filter.
// No dependencies; imported by dksf_bank and the top level.
package dksf_pkg;

  localparam int unsigned SourcesDefault      = 4;
  localparam int unsigned HistoryDepthDefault = 256;
  localparam int unsigned KeyW                = 32;

  localparam logic [7:0] AnnounceType = 8'h4E;

  typedef struct packed {
    logic [1:0]      source_index;
    logic [7:0]      message_type;
    logic [KeyW-1:0] node_key;
  } req_t;

  typedef struct packed {
    logic forward;
    logic duplicate;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StDrain = 3'b100
  } state_e;

endpackage

// ===== design/dksf_bank.sv =====
// One history ring: key memory, write pointer with fill flag, and key compare.
// Depends on dksf_pkg.
module dksf_bank #(
  parameter int unsigned Depth = dksf_pkg::HistoryDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(Depth)-1:0]      rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [dksf_pkg::KeyW-1:0]     key_i,
  output logic                          hit_o
);
  import dksf_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [KeyW-1:0]  mem [Depth];
  logic [KeyW-1:0]  rdata_q;
  logic [AddrW-1:0] raddr_q;
  logic             rvalid_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             full_q, full_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[ptr_q] <= key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      raddr_q <= rd_addr_i;
    end
  end

  always_comb begin
    ptr_d  = ptr_q;
    full_d = full_q;
    if (wr_en_i) begin
      if (ptr_q == LastAddr) begin
        ptr_d  = '0;
        full_d = 1'b1;
      end else begin
        ptr_d = ptr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      ptr_q    <= '0;
      full_q   <= 1'b0;
    end else begin
      rvalid_q <= rd_en_i;
      ptr_q    <= ptr_d;
      full_q   <= full_d;
    end
  end

  // slots below the pointer are filled; once wrapped, all are
  assign hit_o = rvalid_q && (full_q || (raddr_q < ptr_q)) && (rdata_q == key_i);

endmodule

// ===== design/duplicate_key_suppression_filter.sv =====
// Top level of the duplicate key suppression filter: sequencer, hit accumulator
// and one dksf_bank per source. Depends on dksf_pkg and dksf_bank.
//
// Usage
//   Request channel: a request (source index, message type, node key) is taken
//   at a rising edge with start high and busy low.
//   Result channel: valid_o is high for exactly one cycle with rsp_o; the
//   receiver must take it then, it cannot stall the block.
//   Result timing and busy:
//   - message type other than 0x4E: result in the cycle after the request, both
//     flags low; busy stays low, so such requests may follow back to back.
//   - 0x4E announcement: all source rings are read in parallel, one address per
//     cycle, over every ring address, then the last read data is compared in
//     the drain state. busy is high through the scan and drain states, and the
//     result is registered from the drain state.
//   Recording: the key is written to its source's ring in the final compare
//   cycle; sources at or above Sources are compared but never recorded.
//   Reset: rings read as empty (pointers and fill flags cleared), no clearing
//   pass is needed; the block accepts requests straight after reset.
module duplicate_key_suppression_filter #(
  parameter int unsigned Sources      = dksf_pkg::SourcesDefault,
  parameter int unsigned HistoryDepth = dksf_pkg::HistoryDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dksf_pkg::req_t req_i,
  output logic           valid_o,
  output dksf_pkg::rsp_t rsp_o
);
  import dksf_pkg::*;

  localparam int unsigned AddrW = $clog2(HistoryDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HistoryDepth - 1);

  state_e           state_q, state_d;
  req_t             req_q;
  logic [AddrW-1:0] scan_q, scan_d;
  logic             hit_q, hit_d;
  logic             valid_q, valid_d;
  rsp_t             rsp_q, rsp_d;
  logic             accept;
  logic [Sources-1:0] bank_hit;
  logic             any_hit;
  logic             wr_go;

  assign accept  = start && !busy;
  assign busy    = (state_q != StIdle);
  assign any_hit = |bank_hit;
  // record in the last compare cycle, after every stored key was checked
  assign wr_go   = (state_q == StDrain);

  for (genvar s = 0; s < Sources; s++) begin : g_bank
    logic wr_en;
    assign wr_en = wr_go && (int'(req_q.source_index) == s);

    dksf_bank #(
      .Depth(HistoryDepth)
    ) u_bank (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .rd_en_i  (state_q == StScan),
      .rd_addr_i(scan_q),
      .wr_en_i  (wr_en),
      .key_i    (req_q.node_key),
      .hit_o    (bank_hit[s])
    );
  end

  // Sequencer: idle -> scan (one address per cycle) -> drain (last compare,
  // write back, result) -> idle. Non-announcements answer straight from idle.
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    hit_d   = hit_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.message_type == AnnounceType) begin
            state_d = StScan;
            scan_d  = '0;
            hit_d   = 1'b0;
          end else begin
            valid_d = 1'b1;
            rsp_d   = '0;
          end
        end
      end
      StScan: begin
        hit_d = hit_q | any_hit;
        if (scan_q == LastAddr) begin
          state_d = StDrain;
        end else begin
          scan_d = scan_q + AddrW'(1);
        end
      end
      StDrain: begin
        valid_d         = 1'b1;
        rsp_d.duplicate = hit_q | any_hit;
        rsp_d.forward   = !(hit_q | any_hit);
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      scan_q  <= '0;
      hit_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // A result only follows a non-announcement request or the drain cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q == StDrain) || $past(accept)))
    else $error("result strobe without a finished request");

  // Forward and duplicate are never raised together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(rsp_o.forward && rsp_o.duplicate))
    else $error("forward and duplicate both set");

  // The scan ends after the last address and always passes through drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && scan_q == LastAddr) |=> (state_q == StDrain))
    else $error("scan did not end in drain");

  // No result is emitted while the rings are being scanned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !valid_o)
    else $error("result strobe during scan");

endmodule
